### hw/rtl/im2col_pkg.sv
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared types and constants for the im2col scatter address generator: the
// register map, the configuration bundle, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package im2col_pkg;

    // Saturation limits applied to the mask size and the image dimensions.
    localparam int MAX_MASK = 7;
    localparam int MAX_DIM  = 256;

    // Port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;

    // Bit positions of the input fields within s_axis_tdata.
    localparam int IN_BATCH_LSB   = 0;
    localparam int IN_CHANNEL_LSB = 4;
    localparam int IN_ROW_LSB     = 10;
    localparam int IN_COL_LSB     = 18;
    localparam int IN_BITS_LSB    = 26;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BATCH_COUNT   = 3'd0,
        REG_CHANNEL_COUNT = 3'd1,
        REG_IMAGE_HEIGHT  = 3'd2,
        REG_IMAGE_WIDTH   = 3'd3,
        REG_MASK_SIZE     = 3'd4
    } cfg_reg_t;

    // Current contents of the configuration registers.
    typedef struct packed {
        logic [4:0] batch_count;
        logic [6:0] channel_count;
        logic [8:0] image_height;
        logic [8:0] image_width;
        logic [2:0] mask_size;
    } cfg_t;

    // Controller states: four set-up steps, then one write per cycle while the output register is free.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC_A,
        ST_CALC_B,
        ST_CALC_C,
        ST_CALC_D,
        ST_RUN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic calc_a;
        logic calc_b;
        logic calc_c;
        logic calc_d;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_ok;
        logic out_free;
        logic run_last;
    } dp_status_t;

endpackage

### hw/rtl/im2col_scatter_address_gen.sv
// An accepted element passes through the four set-up steps, then the offset walk
// gives its N writes (up to 49), one write per cycle while the output register is free;
// only one element is in work at a time. An element that gives no writes returns
// to idle after the first set-up step.
// Reset: asynchronous, active low; idle, output empty, configuration registers at reset values.
// ----------------------------------------------------------------------------
// im2col_scatter_address_gen
// Scatters one input tensor element into the unrolled im2col matrix of a
// valid, stride-one convolution with a square mask, giving one write per
// mask offset whose output position lies inside the output grid.
// ----------------------------------------------------------------------------
module im2col_scatter_address_gen (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [im2col_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // batch_index[3:0], channel_index[9:4], pixel_row[17:10],
    // pixel_col[25:18], pixel_bits[57:26], zeros above
    input  logic [im2col_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // dest_index[31:0], written_bits[63:32]
    output logic [im2col_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // last_write
    output logic                                m_axis_tlast
);
    import im2col_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Configuration registers.
    im2col_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Controller.
    im2col_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    im2col_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // A write is only issued into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("write issued while the output register was full");

    // Only one element is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready straight after an accepted transfer");

    // The final write of an element returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.run_last) |=> (s_axis_tready && m_axis_tlast))
        else $error("block not idle after the final write of an element");
`endif

endmodule

### hw/rtl/im2col_cfg.sv
// ----------------------------------------------------------------------------
// im2col_cfg
// Configuration register file. Takes one register write per transfer on the
// configuration channel; writes to indexes beyond the register map are
// dropped.
// ----------------------------------------------------------------------------
module im2col_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [im2col_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [im2col_pkg::CFG_DATA_W-1:0]   cfg_data,
    output im2col_pkg::cfg_t                    cfg
);
    import im2col_pkg::*;

    cfg_t cfg_reg;

    // The register file can always take a write.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register writes, each field taking the low bits of the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.batch_count   <= 5'd1;
            cfg_reg.channel_count <= 7'd1;
            cfg_reg.image_height  <= 9'd16;
            cfg_reg.image_width   <= 9'd16;
            cfg_reg.mask_size     <= 3'd7;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BATCH_COUNT:   cfg_reg.batch_count   <= cfg_data[4:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_data[6:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[8:0];
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[8:0];
                REG_MASK_SIZE:     cfg_reg.mask_size     <= cfg_data[2:0];
                default:           ;
            endcase
        end
    end

endmodule

### hw/rtl/im2col_ctrl.sv
// ----------------------------------------------------------------------------
// im2col_ctrl
// Controller state machine. Accepts an element when idle, steps the datapath
// through its set-up calculations and then issues one write per cycle while
// the output register is free.
// ----------------------------------------------------------------------------
module im2col_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  im2col_pkg::dp_status_t  status,
    output im2col_pkg::ctrl_cmd_t   cmd
);
    import im2col_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CALC_A;
                end
            end
            ST_CALC_A:
            begin
                // An element out of range, or a mask that does not fit, gives
                // no writes at all.
                state_next = status.item_ok ? ST_CALC_B : ST_IDLE;
            end
            ST_CALC_B: state_next = ST_CALC_C;
            ST_CALC_C: state_next = ST_CALC_D;
            ST_CALC_D: state_next = ST_RUN;
            ST_RUN:
            begin
                if (status.out_free && status.run_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_CALC_A: cmd.calc_a = 1'b1;
            ST_CALC_B: cmd.calc_b = 1'b1;
            ST_CALC_C: cmd.calc_c = 1'b1;
            ST_CALC_D: cmd.calc_d = 1'b1;
            ST_RUN:    cmd.emit   = status.out_free;
            default:   ;
        endcase
    end

endmodule

### hw/rtl/im2col_dp.sv
// ----------------------------------------------------------------------------
// im2col_dp
// Datapath. Holds the element, works out the range of valid mask offsets and
// the base terms of the destination index over four set-up steps, then walks
// the offsets with additions only, one write per step into the output
// register.
// ----------------------------------------------------------------------------
module im2col_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  im2col_pkg::cfg_t                    cfg,
    input  im2col_pkg::ctrl_cmd_t               cmd,
    output im2col_pkg::dp_status_t              status,
    input  logic [im2col_pkg::IN_TDATA_W-1:0]   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [im2col_pkg::OUT_TDATA_W-1:0]  out_data,
    output logic                                out_last
);
    import im2col_pkg::*;

    // Held element.
    logic [3:0]  held_batch_reg;
    logic [5:0]  held_channel_reg;
    logic [7:0]  held_row_reg;
    logic [7:0]  held_col_reg;
    logic [31:0] held_bits_reg;

    // First set-up step results.
    logic [8:0]  hout_reg;
    logic [8:0]  wout_reg;
    logic [2:0]  k_reg;
    logic [5:0]  kk_reg;
    logic [11:0] bc_reg;
    logic [2:0]  mr_lo_reg;
    logic [2:0]  mr_hi_reg;
    logic [2:0]  mc_lo_reg;
    logic [2:0]  mc_hi_reg;
    logic [7:0]  ro0_reg;
    logic [7:0]  co0_reg;

    // Second and third set-up step results.
    logic [16:0] plane_reg;
    logic [17:0] rb_reg;
    logic [16:0] pw_reg;
    logic [17:0] rstart_reg;
    logic [19:0] kp_reg;
    logic [16:0] pos0_reg;

    // Offset walk.
    logic [2:0]  mr_cur_reg;
    logic [2:0]  mc_cur_reg;
    logic [31:0] row_start_reg;
    logic [31:0] row_cur_reg;
    logic [16:0] pos_start_reg;
    logic [16:0] pos_cur_reg;

    // Output register.
    logic        out_valid_reg;
    logic [31:0] dest_reg;
    logic [31:0] out_bits_reg;
    logic        out_last_reg;

    // Combinational terms.
    logic [2:0]  k_sat;
    logic [8:0]  h_sat;
    logic [8:0]  w_sat;
    logic [8:0]  hout_a;
    logic [8:0]  wout_a;
    logic [5:0]  kk_a;
    logic [10:0] bmul_a;
    logic [11:0] bc_a;
    logic [2:0]  mr_lo_a;
    logic [2:0]  mr_hi_a;
    logic [2:0]  mc_lo_a;
    logic [2:0]  mc_hi_a;
    logic [5:0]  mrk_c;
    logic [34:0] row_init_d;
    logic        row_end;
    logic [2:0]  mr_cur_next;
    logic [2:0]  mc_cur_next;
    logic [31:0] row_start_next;
    logic [31:0] row_cur_next;
    logic [16:0] pos_start_next;
    logic [16:0] pos_cur_next;

    // Saturated configuration.
    assign k_sat = (4'(cfg.mask_size) > 4'(MAX_MASK)) ? 3'(MAX_MASK) : cfg.mask_size;
    assign h_sat = (10'(cfg.image_height) > 10'(MAX_DIM)) ? 9'(MAX_DIM) : cfg.image_height;
    assign w_sat = (10'(cfg.image_width) > 10'(MAX_DIM)) ? 9'(MAX_DIM) : cfg.image_width;

    // Output grid size and the element's row in the unrolled matrix.
    assign hout_a = h_sat - 9'(k_sat) + 9'd1;
    assign wout_a = w_sat - 9'(k_sat) + 9'd1;
    assign kk_a   = 6'(k_sat) * 6'(k_sat);
    assign bmul_a = 11'(held_batch_reg) * 11'(cfg.channel_count);
    assign bc_a   = 12'(bmul_a) + 12'(held_channel_reg);

    // Range of valid offsets: an offset m is valid when m <= pos and
    // pos - m < out, so the valid offsets form one interval per axis.
    assign mr_lo_a = ({1'b0, held_row_reg} >= hout_a)
                     ? 3'({1'b0, held_row_reg} - hout_a + 9'd1) : 3'd0;
    assign mr_hi_a = ((8'(k_sat) - 8'd1) > held_row_reg)
                     ? held_row_reg[2:0] : k_sat - 3'd1;
    assign mc_lo_a = ({1'b0, held_col_reg} >= wout_a)
                     ? 3'({1'b0, held_col_reg} - wout_a + 9'd1) : 3'd0;
    assign mc_hi_a = ((8'(k_sat) - 8'd1) > held_col_reg)
                     ? held_col_reg[2:0] : k_sat - 3'd1;

    // Indexes in range and a mask that fits inside the image.
    assign status.item_ok = ({1'b0, held_batch_reg} < cfg.batch_count)
                         && ({1'b0, held_channel_reg} < cfg.channel_count)
                         && ({1'b0, held_row_reg} < h_sat)
                         && ({1'b0, held_col_reg} < w_sat)
                         && (k_sat != 3'd0)
                         && (h_sat >= 9'(k_sat))
                         && (w_sat >= 9'(k_sat));

    // Set-up products.
    assign mrk_c      = 6'(mr_lo_reg) * 6'(k_reg);
    assign row_init_d = 35'(rstart_reg) * 35'(plane_reg);

    // Offset walk: along a mask row the matrix row advances by one and the
    // output column falls by one; at the row end both restart from the
    // saved row start, moved on by one mask row.
    assign row_end = (mc_cur_reg == mc_hi_reg);
    assign status.run_last = row_end && (mr_cur_reg == mr_hi_reg);

    always_comb
    begin
        mr_cur_next    = mr_cur_reg;
        mc_cur_next    = mc_cur_reg + 3'd1;
        row_start_next = row_start_reg;
        row_cur_next   = row_cur_reg + 32'(plane_reg);
        pos_start_next = pos_start_reg;
        pos_cur_next   = pos_cur_reg - 17'd1;
        if (row_end)
        begin
            mr_cur_next    = mr_cur_reg + 3'd1;
            mc_cur_next    = mc_lo_reg;
            row_start_next = row_start_reg + 32'(kp_reg);
            row_cur_next   = row_start_next;
            pos_start_next = pos_start_reg - 17'(wout_reg);
            pos_cur_next   = pos_start_next;
        end
    end

    // Output register is free when empty or being drained this cycle.
    assign status.out_free = !out_valid_reg || out_ready;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            held_batch_reg   <= in_data[IN_BATCH_LSB +: 4];
            held_channel_reg <= in_data[IN_CHANNEL_LSB +: 6];
            held_row_reg     <= in_data[IN_ROW_LSB +: 8];
            held_col_reg     <= in_data[IN_COL_LSB +: 8];
            held_bits_reg    <= in_data[IN_BITS_LSB +: 32];
        end
        if (cmd.calc_a)
        begin
            hout_reg  <= hout_a;
            wout_reg  <= wout_a;
            k_reg     <= k_sat;
            kk_reg    <= kk_a;
            bc_reg    <= bc_a;
            mr_lo_reg <= mr_lo_a;
            mr_hi_reg <= mr_hi_a;
            mc_lo_reg <= mc_lo_a;
            mc_hi_reg <= mc_hi_a;
            ro0_reg   <= held_row_reg - 8'(mr_lo_a);
            co0_reg   <= held_col_reg - 8'(mc_lo_a);
        end
        if (cmd.calc_b)
        begin
            plane_reg <= 17'(hout_reg) * 17'(wout_reg);
            rb_reg    <= 18'(bc_reg) * 18'(kk_reg);
            pw_reg    <= 17'(ro0_reg) * 17'(wout_reg);
        end
        if (cmd.calc_c)
        begin
            rstart_reg <= rb_reg + 18'(mrk_c) + 18'(mc_lo_reg);
            kp_reg     <= 20'(k_reg) * 20'(plane_reg);
            pos0_reg   <= pw_reg + 17'(co0_reg);
        end
        if (cmd.calc_d)
        begin
            mr_cur_reg    <= mr_lo_reg;
            mc_cur_reg    <= mc_lo_reg;
            row_start_reg <= row_init_d[31:0];
            row_cur_reg   <= row_init_d[31:0];
            pos_start_reg <= pos0_reg;
            pos_cur_reg   <= pos0_reg;
        end
        else if (cmd.emit)
        begin
            mr_cur_reg    <= mr_cur_next;
            mc_cur_reg    <= mc_cur_next;
            row_start_reg <= row_start_next;
            row_cur_reg   <= row_cur_next;
            pos_start_reg <= pos_start_next;
            pos_cur_reg   <= pos_cur_next;
        end
        if (cmd.emit)
        begin
            dest_reg     <= row_cur_reg + 32'(pos_cur_reg);
            out_bits_reg <= held_bits_reg;
            out_last_reg <= status.run_last;
        end
    end

    // Output valid flag: set by a write, cleared once the transfer is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {out_bits_reg, dest_reg};
    assign out_last  = out_last_reg;

endmodule
